### src/sks_pkg.sv
// sorted key set package: sizes, command codes, state encoding and the
// control word broadcast to the row of cells
// no dependencies
package sks_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 64;
  localparam int CMD_W    = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic             rem_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

### src/sks_cell.sv
// one storage cell of the sorted key set: holds a key, compares it with the
// broadcast key and shifts to or from its neighbors
// depends on sks_pkg
module sks_cell (
  input  logic                       clk,
  input  sks_pkg::cell_ctrl_t        ctrl,
  input  logic                       occupied,
  input  logic                       left_lt,
  input  logic [sks_pkg::KEY_W-1:0]  left_key,
  input  logic [sks_pkg::KEY_W-1:0]  right_key,
  output logic [sks_pkg::KEY_W-1:0]  key_out,
  output logic                       lt,
  output logic                       eq
);
  import sks_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             lt_q;
  logic             eq_q;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_q <= occupied && (key_q < ctrl.key);
      eq_q <= occupied && (key_q == ctrl.key);
    end
    if (ctrl.ins_en && !lt_q) begin
      key_q <= left_lt ? ctrl.key : left_key;
    end else if (ctrl.rem_en && !lt_q) begin
      key_q <= right_key;
    end
  end

  assign key_out = key_q;
  assign lt      = lt_q;
  assign eq      = eq_q;

endmodule

### src/sks_encode.sv
// turns the row of less-than and equal flags into the ordered position and
// the presence bit
// depends on sks_pkg
module sks_encode (
  input  logic [sks_pkg::CAPACITY-1:0] lt,
  input  logic [sks_pkg::CAPACITY-1:0] eq,
  output logic [sks_pkg::CNT_W-1:0]    position,
  output logic                         present
);
  import sks_pkg::*;

  logic [CAPACITY:0] edges;

  // less-than flags form a run of ones from cell 0, so the edge is one-hot
  always_comb begin
    edges[0] = !lt[0];
    for (int i = 1; i < CAPACITY; i++) begin
      edges[i] = lt[i-1] && !lt[i];
    end
    edges[CAPACITY] = lt[CAPACITY-1];
  end

  always_comb begin
    position = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      position = position | (edges[i] ? CNT_W'(i) : '0);
    end
  end

  assign present = |eq;

endmodule

### src/sorted_key_set.sv
// sorted key set top level: row of key cells, position encoder, control
// depends on sks_pkg, sks_cell, sks_encode
//
// Holds up to CAPACITY distinct 64-bit keys in ascending order, one key per
// cell. For each command, in order: the word is registered, every cell
// compares its key with it in parallel, then the position is encoded and the
// cells shift up (add) or down (remove) in one step while the result is
// loaded into the output register. A new word is taken once the previous one
// has reached the output register, so a waiting result does not hold off the
// next command; it only holds the apply step of that command.
module sorted_key_set (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sks_pkg::CMD_W-1:0]   command,
  input  logic [sks_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        was_present,
  output logic [sks_pkg::CNT_W-1:0]   position,
  output logic [sks_pkg::CNT_W-1:0]   entry_total,
  output logic                        full_refused
);
  import sks_pkg::*;

  state_t           state;
  state_t           state_next;
  cmd_t             cmd;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid_next;
  logic             load;

  cell_ctrl_t       ctrl;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [KEY_W-1:0]    keys [CAPACITY];
  logic [CNT_W-1:0]    pos;
  logic                present;
  logic                full;
  logic                do_ins;
  logic                do_rem;
  logic                refuse;

  assign in_stall = (state != S_IDLE);
  assign full     = (count == CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd   <= cmd_t'(command);
      key_q <= key;
    end
  end

  assign load   = (state == S_APPLY) && (!out_valid || !out_stall);
  assign do_ins = load && (cmd == CMD_ADD) && !present && !full;
  assign do_rem = load && (cmd == CMD_REMOVE) && present;
  assign refuse = (cmd == CMD_ADD) && !present && full;

  assign ctrl.cmp_en = (state == S_CMP);
  assign ctrl.ins_en = do_ins;
  assign ctrl.rem_en = do_rem;
  assign ctrl.key    = key_q;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic             occ;
      logic             l_lt;
      logic [KEY_W-1:0] l_key;
      logic [KEY_W-1:0] r_key;

      assign occ = (count > CNT_W'(g));
      if (g == 0) begin : g_first
        assign l_lt  = 1'b1;
        assign l_key = '0;
      end else begin : g_mid
        assign l_lt  = lt[g-1];
        assign l_key = keys[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign r_key = '0;
      end else begin : g_inner
        assign r_key = keys[g+1];
      end

      sks_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ),
        .left_lt   (l_lt),
        .left_key  (l_key),
        .right_key (r_key),
        .key_out   (keys[g]),
        .lt        (lt[g]),
        .eq        (eq[g])
      );
    end
  endgenerate

  sks_encode u_encode (
    .lt       (lt),
    .eq       (eq),
    .position (pos),
    .present  (present)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (load) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
          priority if (cmd == CMD_CLEAR) begin
            count_next = '0;
          end else if (do_ins) begin
            count_next = count + CNT_W'(1);
          end else if (do_rem) begin
            count_next = count - CNT_W'(1);
          end else begin
            count_next = count;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd == CMD_CLEAR) begin
        was_present  <= 1'b0;
        position     <= '0;
        full_refused <= 1'b0;
      end else begin
        was_present  <= present;
        position     <= pos;
        full_refused <= refuse;
      end
      entry_total <= count_next;
    end
  end

  // checks
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_lt_run : assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> (lt & (lt + CAPACITY'(1))) == '0)
    else $error("less-than flags not a run from cell 0");

  a_eq_single : assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> $onehot0(eq))
    else $error("key matched in more than one cell");

  a_refuse_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && full_refused |-> entry_total == CNT_W'(CAPACITY))
    else $error("add refused while store not full");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    load && cmd != CMD_CLEAR |=> (count == $past(count)) ||
      (count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1)))
    else $error("key count moved by more than one");

endmodule

### bench/tb_sorted_key_set.sv
// testbench for sorted_key_set: directed and randomized command traffic against a shadow set
// depends on sks_pkg and the sorted_key_set rtl
module tb_sorted_key_set;
  timeunit 1ns;
  timeprecision 1ps;

  import sks_pkg::*;

  localparam int HOLD_LEN   = 300;
  localparam int POOL_SIZE  = 70;
  localparam int MIX_WORDS  = 100;

  typedef struct {
    cmd_t             op;
    logic [KEY_W-1:0] key;
  } set_word_t;

  typedef struct packed {
    logic             was_present;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] entry_total;
    logic             full_refused;
  } set_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [KEY_W-1:0] key = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             was_present;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] entry_total;
  logic             full_refused;

  set_word_t        pending_words [$];
  set_result_t      predicted_results [$];
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  int               shadow_count = 0;
  logic [KEY_W-1:0] key_pool [$];

  int   queued_total = 0;
  int   accepted_total = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic in_fired = 1'b0;
  logic hold_active = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;

  sorted_key_set dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .key          (key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .was_present  (was_present),
    .position     (position),
    .entry_total  (entry_total),
    .full_refused (full_refused)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic set_result_t apply_to_shadow_set(cmd_t op, logic [KEY_W-1:0] k);
    set_result_t r;
    int          slot;
    int          i;
    r = '0;
    if (op == CMD_CLEAR) begin
      shadow_count = 0;
    end else begin
      slot = 0;
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_keys[i] < k) slot++;
      end
      r.was_present = (slot < shadow_count) && (shadow_keys[slot] == k);
      r.position = slot[CNT_W-1:0];
      if (op == CMD_ADD && !r.was_present) begin
        if (shadow_count >= CAPACITY) begin
          r.full_refused = 1'b1;
        end else begin
          for (i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[slot] = k;
          shadow_count++;
        end
      end else if (op == CMD_REMOVE && r.was_present) begin
        for (i = slot; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_count--;
      end
    end
    r.entry_total = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin : feed
    set_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        command  <= w.op;
        key      <= w.key;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and long hold
  always @(negedge clk) begin
    if (rst || !hold_active) begin
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_count == HOLD_LEN) begin
      hold_done <= 1'b1;
    end else begin
      hold_count <= hold_count + 1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_active && !hold_done) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    set_result_t want;
    set_result_t got;
    if (rst) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = {was_present, position, entry_total, full_refused};
        if (predicted_results.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result word: present %0d pos %0d total %0d refused %0d",
                     got.was_present, got.position, got.entry_total, got.full_refused);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.was_present != want.was_present || got.position != want.position ||
              got.entry_total != want.entry_total || got.full_refused != want.full_refused)
          begin
            if (error_count < 10) begin
              $display("mismatch: expected present %0d pos %0d total %0d refused %0d",
                       want.was_present, want.position, want.entry_total, want.full_refused);
              $display("          got present %0d pos %0d total %0d refused %0d",
                       got.was_present, got.position, got.entry_total, got.full_refused);
            end
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(apply_to_shadow_set(cmd_t'(command), key));
        accepted_total++;
      end
    end
  end

  task automatic push_word(cmd_t op, logic [KEY_W-1:0] k);
    set_word_t w;
    w.op = op;
    w.key = k;
    pending_words.push_back(w);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // pool of distinct keys with clusters and values near the extremes, in random order
  task automatic build_key_pool();
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] k;
    logic             seen;
    int               i;
    int               j;
    base = random_key();
    key_pool.delete();
    while (key_pool.size() < POOL_SIZE) begin
      case ($urandom_range(3))
        0: k = random_key();
        1: k = base + KEY_W'($urandom_range(20));
        2: k = {($urandom_range(1) != 0) ? 32'h0 : 32'hFFFF_FFFF, $urandom};
        default: k = ($urandom_range(1) != 0) ? KEY_W'($urandom_range(3))
                                              : ~KEY_W'($urandom_range(3));
      endcase
      seen = 1'b0;
      for (j = 0; j < key_pool.size(); j++) begin
        if (key_pool[j] == k) seen = 1'b1;
      end
      if (!seen) key_pool.push_back(k);
    end
    for (i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      k = key_pool[i];
      key_pool[i] = key_pool[j];
      key_pool[j] = k;
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    int i;
    int roll;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    build_key_pool();
    push_word(CMD_CLEAR, random_key());
    // fill past capacity, then re-add a held key while full
    for (i = 0; i < POOL_SIZE; i++) push_word(CMD_ADD, key_pool[i]);
    push_word(CMD_ADD, key_pool[0]);
    push_word(CMD_QUERY, key_pool[POOL_SIZE-1]);
    for (i = 0; i < MIX_WORDS; i++) begin
      roll = $urandom_range(99);
      if (roll < 30)
        push_word(CMD_ADD, key_pool[$urandom_range(POOL_SIZE-1)]);
      else if (roll < 52)
        push_word(CMD_REMOVE, key_pool[$urandom_range(POOL_SIZE-1)]);
      else if (roll < 75)
        push_word(CMD_QUERY, key_pool[$urandom_range(POOL_SIZE-1)]);
      else if (roll < 90)
        push_word(cmd_t'($urandom_range(3, 1)), random_key());
      else if (roll < 92)
        push_word(CMD_CLEAR, random_key());
      else
        push_word(CMD_ADD, random_key());
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words
    push_word(CMD_QUERY, '0);
    push_word(CMD_REMOVE, 64'd5);
    push_word(CMD_ADD, '1);
    push_word(CMD_ADD, '0);
    push_word(CMD_ADD, '0);
    push_word(CMD_QUERY, '1);
    push_word(CMD_ADD, 64'h8000_0000_0000_0000);
    push_word(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
    push_word(CMD_QUERY, 64'h7FFF_FFFF_FFFF_FFFE);
    push_word(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFE);
    push_word(CMD_REMOVE, '0);
    push_word(CMD_REMOVE, '0);
    push_word(CMD_QUERY, '0);
    push_word(CMD_ADD, 64'd1);
    push_word(CMD_REMOVE, 64'h8000_0000_0000_0000);
    push_word(CMD_CLEAR, '1);
    push_word(CMD_QUERY, '1);
    push_word(CMD_REMOVE, '1);
    push_word(CMD_ADD, 64'hA5A5_5A5A_0F0F_F0F0);
    push_word(CMD_CLEAR, '0);
    wait_drained();

    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(21, 21);

    // long receiver hold while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_active = 1'b1;
    for (int i = 0; i < 40; i++) push_word(cmd_t'($urandom_range(3)), random_key());
    while (!hold_done) @(negedge clk);
    hold_active = 1'b0;
    wait_drained();

    repeat (20) @(negedge clk);
    if (predicted_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
